// File: rtl/acpu_pkg.sv
// Package with opcodes, sizes and shared types of the accumulator CPU.
package acpu_pkg;

    localparam int AddrWidthDef = 16;
    localparam int RegCountDef  = 8;

    localparam logic [15:0] RetLowSlot  = 16'hFFFE;
    localparam logic [15:0] RetHighSlot = 16'hFFFF;

    typedef enum logic [4:0] {
        OP_HLT  = 5'd0,  OP_OUT  = 5'd1,  OP_NOP  = 5'd2,  OP_MVI  = 5'd3,
        OP_STA  = 5'd4,  OP_LDA  = 5'd5,  OP_ADD  = 5'd6,  OP_ADC  = 5'd7,
        OP_SUB  = 5'd8,  OP_SBB  = 5'd9,  OP_INR  = 5'd10, OP_DCR  = 5'd11,
        OP_MOV  = 5'd12, OP_JMP  = 5'd13, OP_JZ   = 5'd14, OP_JNZ  = 5'd15,
        OP_JM   = 5'd16, OP_CALL = 5'd17, OP_RET  = 5'd18, OP_CMA  = 5'd19,
        OP_ANA  = 5'd20, OP_ANI  = 5'd21, OP_ORA  = 5'd22, OP_ORI  = 5'd23,
        OP_XRA  = 5'd24, OP_XRI  = 5'd25, OP_RAL  = 5'd26, OP_RAR  = 5'd27,
        OP_HWR  = 5'd28
    } t_op;

endpackage

// File: rtl/accumulator_cpu_instruction_execute.sv
// Top level: executes one instruction per transfer against a byte memory.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | op, selects, host address and data
//  output  | out       | o_valid / i_stall  | pc, accumulator, flags, halted, strobe
//
// An instruction steps from its transfer to the registering of its result as
// the single memory port with registered read data allows: S_RD1 and S_DONE
// for register ops, host writes and jumps not taken; S_RD2 too for immediate
// byte ops; S_RD2 and S_RD3 for taken jumps, sta and ret; S_WR2 as well for
// lda and call. The next transfer is taken in S_DONE, gapless unless stalled.
// Reset clears pc, flags, the register file and the control; memory keeps
// its contents. A result waits in the output register under i_stall while the
// next instruction is already taken and worked on.
module accumulator_cpu_instruction_execute #(
    parameter int ADDR_WIDTH = acpu_pkg::AddrWidthDef,
    parameter int REG_COUNT  = acpu_pkg::RegCountDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_op,
    input  logic [2:0]  i_dest_select,
    input  logic [2:0]  i_source_select,
    input  logic [15:0] i_host_address,
    input  logic [7:0]  i_host_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_program_counter,
    output logic [7:0]  o_accumulator,
    output logic        o_zero_flag,
    output logic        o_sign_flag,
    output logic        o_carry_flag,
    output logic        o_halted,
    output logic        o_output_strobe
);

    localparam int MemDepth = 1 << ADDR_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_RD3, S_WR2, S_DONE
    } t_state;

    // Byte memory: one port, registered read data.
    logic [7:0] r_mem [MemDepth];
    logic [7:0] r_rdata;
    logic       mem_we;
    logic [ADDR_WIDTH-1:0] mem_addr;
    logic [7:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    // Architectural state.
    logic [7:0]  r_regs [8];
    logic [15:0] r_pc;
    logic        r_z, r_s, r_c;

    // Current instruction.
    t_state      r_state;
    acpu_pkg::t_op r_op;
    logic [2:0]  r_dsel, r_ssel;
    logic [15:0] r_haddr;
    logic [7:0]  r_hdata;
    logic [7:0]  r_lo;
    logic [7:0]  r_ret_hi;
    logic        r_busy_in;

    // Output register.
    logic        r_ovalid;
    logic [15:0] r_opc;
    logic [7:0]  r_oacc;
    logic        r_oz, r_os, r_oc, r_oh, r_ostr;

    logic out_free;
    assign out_free = !r_ovalid || !i_stall;

    // Accept when no instruction is in work, or one finishes this cycle.
    logic take;
    assign o_stall = r_busy_in && !(r_state == S_DONE && out_free);
    assign take    = i_valid && !o_stall;

    // Operand classes.
    logic need_byte, need_word, is_ret;
    always_comb begin
        need_byte = (r_op == acpu_pkg::OP_MVI) || (r_op == acpu_pkg::OP_ANI) ||
                    (r_op == acpu_pkg::OP_ORI) || (r_op == acpu_pkg::OP_XRI);
        need_word = (r_op == acpu_pkg::OP_STA) || (r_op == acpu_pkg::OP_LDA) ||
                    (r_op == acpu_pkg::OP_JMP) || (r_op == acpu_pkg::OP_CALL) ||
                    (r_op == acpu_pkg::OP_JZ  && r_z)  ||
                    (r_op == acpu_pkg::OP_JNZ && !r_z) ||
                    (r_op == acpu_pkg::OP_JM  && r_s);
        is_ret    = (r_op == acpu_pkg::OP_RET);
    end

    // Register reads with missing registers reading as zero.
    function automatic logic reg_ok(input logic [2:0] sel);
        return 32'(sel) < REG_COUNT;
    endfunction

    logic [7:0]  acc, src, dst;
    logic [15:0] pc1, pc2, pc3, word;
    assign acc  = r_regs[0];
    assign src  = reg_ok(r_ssel) ? r_regs[r_ssel] : 8'd0;
    assign dst  = reg_ok(r_dsel) ? r_regs[r_dsel] : 8'd0;
    assign pc1  = r_pc + 16'd1;
    assign pc2  = r_pc + 16'd2;
    assign pc3  = r_pc + 16'd3;
    assign word = {r_rdata, r_lo};

    // Memory port control by step.
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = ADDR_WIDTH'(pc1);
        mem_wdata = acc;
        case (r_state)
            S_IDLE: begin
                mem_addr = ADDR_WIDTH'(pc1);
            end
            S_RD1: begin
                if (is_ret) mem_addr = ADDR_WIDTH'(acpu_pkg::RetLowSlot);
                else        mem_addr = ADDR_WIDTH'(pc1);
                if (r_op == acpu_pkg::OP_HWR) begin
                    mem_we    = 1'b1;
                    mem_addr  = ADDR_WIDTH'(r_haddr);
                    mem_wdata = r_hdata;
                end
            end
            S_RD2: begin
                if (is_ret) mem_addr = ADDR_WIDTH'(acpu_pkg::RetHighSlot);
                else        mem_addr = ADDR_WIDTH'(pc2);
            end
            S_RD3: begin
                mem_addr = ADDR_WIDTH'(word);
                if (r_op == acpu_pkg::OP_STA) begin
                    mem_we = 1'b1;
                end else if (r_op == acpu_pkg::OP_CALL) begin
                    mem_we    = 1'b1;
                    mem_addr  = ADDR_WIDTH'(acpu_pkg::RetLowSlot);
                    mem_wdata = pc3[7:0];
                end
            end
            S_WR2: begin
                // Only call writes here; lda waits for its load data.
                if (r_op == acpu_pkg::OP_CALL) begin
                    mem_we    = 1'b1;
                    mem_addr  = ADDR_WIDTH'(acpu_pkg::RetHighSlot);
                    mem_wdata = r_ret_hi;
                end
            end
            default: ;
        endcase
    end

    // Sequencer, execute and output register.
    always_ff @(posedge i_clk) begin
        logic [8:0] sum;
        logic [7:0] res;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy_in <= 1'b0;
            r_ovalid  <= 1'b0;
            r_pc      <= '0;
            r_z       <= 1'b0;
            r_s       <= 1'b0;
            r_c       <= 1'b0;
            for (int k = 0; k < 8; k++) r_regs[k] <= '0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: ;
                S_RD1: begin
                    // Memory data for pc+1 or the low return byte comes next.
                    if (need_byte || need_word || is_ret) r_state <= S_RD2;
                    else                                  r_state <= S_DONE;
                end
                S_RD2: begin
                    r_lo <= r_rdata;
                    if (need_byte) r_state <= S_DONE;
                    else           r_state <= S_RD3;
                end
                S_RD3: begin
                    // r_rdata holds the high byte; word is complete here.
                    // The return high byte is kept before pc moves to the target.
                    r_ret_hi <= pc3[15:8];
                    if (r_op == acpu_pkg::OP_CALL || r_op == acpu_pkg::OP_LDA)
                        r_state <= S_WR2;
                    else
                        r_state <= S_DONE;
                    case (r_op)
                        acpu_pkg::OP_JMP, acpu_pkg::OP_JZ, acpu_pkg::OP_JNZ,
                        acpu_pkg::OP_JM, acpu_pkg::OP_CALL, acpu_pkg::OP_RET:
                            r_pc <= word;
                        acpu_pkg::OP_STA: r_pc <= pc3;
                        default: ;
                    endcase
                end
                S_WR2: begin
                    // Return high byte written, or load data arrives.
                    if (r_op == acpu_pkg::OP_LDA) begin
                        r_regs[0] <= r_rdata;
                        r_pc      <= r_pc + 16'd3;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        r_busy_in <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // Execute: register ops in the first step, immediate byte ops in S_RD2; memory ops finish later.
            if (r_state == S_RD2 && need_byte) begin
                r_pc <= pc2;
                case (r_op)
                    acpu_pkg::OP_MVI: if (reg_ok(r_dsel)) r_regs[r_dsel] <= r_rdata;
                    default: begin
                        case (r_op)
                            acpu_pkg::OP_ANI: res = acc & r_rdata;
                            acpu_pkg::OP_ORI: res = acc | r_rdata;
                            default:          res = acc ^ r_rdata;
                        endcase
                        r_regs[0] <= res;
                        r_z <= (res == 8'd0);
                        r_s <= res[7];
                    end
                endcase
            end
            if (r_state == S_RD1 && !need_byte && !need_word && !is_ret) begin
                res = 8'd0;
                sum = 9'd0;
                case (r_op)
                    acpu_pkg::OP_OUT, acpu_pkg::OP_NOP: r_pc <= pc1;
                    acpu_pkg::OP_ADD: begin
                        sum = {1'b0, acc} + {1'b0, src};
                        r_c <= sum[8];
                        r_regs[0] <= sum[7:0]; r_z <= sum[7:0] == 0; r_s <= sum[7];
                        r_pc <= pc1;
                    end
                    acpu_pkg::OP_ADC: begin
                        sum = {1'b0, acc} + {1'b0, src} + {8'd0, r_c};
                        r_c <= 1'b0;
                        r_regs[0] <= sum[7:0]; r_z <= sum[7:0] == 0; r_s <= sum[7];
                        r_pc <= pc1;
                    end
                    acpu_pkg::OP_SUB: begin
                        sum = {1'b0, acc} - {1'b0, src};
                        r_c <= acc < src;
                        r_regs[0] <= sum[7:0]; r_z <= sum[7:0] == 0; r_s <= sum[7];
                        r_pc <= pc1;
                    end
                    acpu_pkg::OP_SBB: begin
                        sum = {1'b0, acc} - {1'b0, src} - {8'd0, r_c};
                        r_c <= 1'b0;
                        r_regs[0] <= sum[7:0]; r_z <= sum[7:0] == 0; r_s <= sum[7];
                        r_pc <= pc1;
                    end
                    acpu_pkg::OP_INR, acpu_pkg::OP_DCR: begin
                        res = (r_op == acpu_pkg::OP_INR) ? dst + 8'd1 : dst - 8'd1;
                        if (reg_ok(r_dsel)) r_regs[r_dsel] <= res;
                        r_z <= res == 0; r_s <= res[7];
                        r_pc <= pc1;
                    end
                    acpu_pkg::OP_MOV: begin
                        if (reg_ok(r_dsel)) r_regs[r_dsel] <= src;
                        r_pc <= pc1;
                    end
                    acpu_pkg::OP_JZ, acpu_pkg::OP_JNZ, acpu_pkg::OP_JM: r_pc <= pc3;
                    acpu_pkg::OP_CMA, acpu_pkg::OP_ANA, acpu_pkg::OP_ORA,
                    acpu_pkg::OP_XRA: begin
                        case (r_op)
                            acpu_pkg::OP_CMA: res = ~acc;
                            acpu_pkg::OP_ANA: res = acc & src;
                            acpu_pkg::OP_ORA: res = acc | src;
                            default:          res = acc ^ src;
                        endcase
                        r_regs[0] <= res; r_z <= res == 0; r_s <= res[7];
                        r_pc <= pc1;
                    end
                    acpu_pkg::OP_RAL: begin
                        r_regs[0] <= {acc[6:0], acc[7]}; r_pc <= pc1;
                    end
                    acpu_pkg::OP_RAR: begin
                        r_regs[0] <= {acc[0], acc[7:1]}; r_pc <= pc1;
                    end
                    default: ;
                endcase
            end

            // Take a new instruction.
            if (take) begin
                r_op      <= acpu_pkg::t_op'(i_op);
                r_dsel    <= i_dest_select;
                r_ssel    <= i_source_select;
                r_haddr   <= i_host_address;
                r_hdata   <= i_host_data;
                r_state   <= S_RD1;
                r_busy_in <= 1'b1;
            end
        end
    end

    // Result capture when the instruction completes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_opc  <= r_pc;
            r_oacc <= r_regs[0];
            r_oz   <= r_z;
            r_os   <= r_s;
            r_oc   <= r_c;
            r_oh   <= (r_op == acpu_pkg::OP_HLT);
            r_ostr <= (r_op == acpu_pkg::OP_OUT);
        end
    end

    assign o_valid           = r_ovalid;
    assign o_program_counter = r_opc;
    assign o_accumulator     = r_oacc;
    assign o_zero_flag       = r_oz;
    assign o_sign_flag       = r_os;
    assign o_carry_flag      = r_oc;
    assign o_halted          = r_oh;
    assign o_output_strobe   = r_ostr;

endmodule

// File: verif/tb_accumulator_cpu_instruction_execute.sv
// Testbench for the accumulator CPU: directed and random programs checked against a behavioral model.
`timescale 1ns / 1ps

module tb_accumulator_cpu_instruction_execute;

    localparam int CycleLimit = 600000;
    localparam int HoldCycles = 300;
    // Two copies of the machine: one steers stimulus, one predicts results.
    localparam int PlanCpu  = 0;
    localparam int CheckCpu = 1;

    typedef struct packed {
        logic [4:0]  op;
        logic [2:0]  dsel;
        logic [2:0]  ssel;
        logic [15:0] haddr;
        logic [7:0]  hdata;
    } t_instr;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  acc;
        logic        zero;
        logic        sign;
        logic        carry;
        logic        halted;
        logic        strobe;
    } t_status;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [4:0]  i_op;
    logic [2:0]  i_dest_select;
    logic [2:0]  i_source_select;
    logic [15:0] i_host_address;
    logic [7:0]  i_host_data;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_program_counter;
    logic [7:0]  o_accumulator;
    logic        o_zero_flag;
    logic        o_sign_flag;
    logic        o_carry_flag;
    logic        o_halted;
    logic        o_output_strobe;

    accumulator_cpu_instruction_execute u_dut (.*);

    // Machine state, one copy per index.
    logic [7:0]  mem_byte [2][65536];
    bit          mem_set  [2][65536];
    logic [7:0]  regs     [2][8];
    logic [15:0] pc_q     [2];
    logic        zf_q     [2];
    logic        sf_q     [2];
    logic        cf_q     [2];

    t_instr  instr_queue[$];
    t_status status_queue[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_req_id;
    int      hold_seen_id;
    int      hold_left;
    int      error_count;
    int      result_count;
    int      instr_count;
    int      cycle_count;

    // Execute one instruction on machine m and return the status it shows.
    function automatic t_status run_instr(input int m, input t_instr it);
        t_status     res;
        logic [7:0]  acc;
        logic [7:0]  src;
        logic [7:0]  val;
        logic [7:0]  imm;
        logic [15:0] pc;
        logic [15:0] n1;
        logic [15:0] n2;
        logic [15:0] n3;
        logic [15:0] word;
        logic [8:0]  sum;
        logic        upd_zs;
        acc    = regs[m][0];
        src    = regs[m][it.ssel];
        pc     = pc_q[m];
        n1     = pc + 16'd1;
        n2     = pc + 16'd2;
        n3     = pc + 16'd3;
        imm    = mem_byte[m][n1];
        word   = {mem_byte[m][n2], mem_byte[m][n1]};
        res    = '0;
        upd_zs = 1'b0;
        val    = acc;
        case (acpu_pkg::t_op'(it.op))
            acpu_pkg::OP_HLT: res.halted = 1'b1;
            acpu_pkg::OP_OUT: begin
                res.strobe = 1'b1;
                pc_q[m] = n1;
            end
            acpu_pkg::OP_NOP: pc_q[m] = n1;
            acpu_pkg::OP_MVI: begin
                regs[m][it.dsel] = imm;
                pc_q[m] = n2;
            end
            acpu_pkg::OP_STA: begin
                mem_byte[m][word] = acc;
                mem_set[m][word] = 1'b1;
                pc_q[m] = n3;
            end
            acpu_pkg::OP_LDA: begin
                regs[m][0] = mem_byte[m][word];
                pc_q[m] = n3;
            end
            acpu_pkg::OP_ADD, acpu_pkg::OP_ADC: begin
                sum = {1'b0, acc} + {1'b0, src};
                if (acpu_pkg::t_op'(it.op) == acpu_pkg::OP_ADC) begin
                    sum = sum + {8'd0, cf_q[m]};
                    cf_q[m] = 1'b0;
                end else begin
                    cf_q[m] = sum[8];
                end
                val = sum[7:0];
                upd_zs = 1'b1;
                pc_q[m] = n1;
            end
            acpu_pkg::OP_SUB: begin
                cf_q[m] = acc < src;
                val = acc - src;
                upd_zs = 1'b1;
                pc_q[m] = n1;
            end
            acpu_pkg::OP_SBB: begin
                val = acc - src - {7'd0, cf_q[m]};
                cf_q[m] = 1'b0;
                upd_zs = 1'b1;
                pc_q[m] = n1;
            end
            acpu_pkg::OP_INR, acpu_pkg::OP_DCR: begin
                val = (acpu_pkg::t_op'(it.op) == acpu_pkg::OP_INR)
                      ? regs[m][it.dsel] + 8'd1 : regs[m][it.dsel] - 8'd1;
                regs[m][it.dsel] = val;
                zf_q[m] = (val == 8'd0);
                sf_q[m] = val[7];
                pc_q[m] = n1;
            end
            acpu_pkg::OP_MOV: begin
                regs[m][it.dsel] = src;
                pc_q[m] = n1;
            end
            acpu_pkg::OP_JMP: pc_q[m] = word;
            acpu_pkg::OP_JZ:  pc_q[m] = zf_q[m] ? word : n3;
            acpu_pkg::OP_JNZ: pc_q[m] = zf_q[m] ? n3 : word;
            acpu_pkg::OP_JM:  pc_q[m] = sf_q[m] ? word : n3;
            acpu_pkg::OP_CALL: begin
                mem_byte[m][acpu_pkg::RetLowSlot]  = n3[7:0];
                mem_byte[m][acpu_pkg::RetHighSlot] = n3[15:8];
                mem_set[m][acpu_pkg::RetLowSlot]   = 1'b1;
                mem_set[m][acpu_pkg::RetHighSlot]  = 1'b1;
                pc_q[m] = word;
            end
            acpu_pkg::OP_RET: pc_q[m] = {mem_byte[m][acpu_pkg::RetHighSlot],
                                         mem_byte[m][acpu_pkg::RetLowSlot]};
            acpu_pkg::OP_CMA: begin val = ~acc;      upd_zs = 1'b1; pc_q[m] = n1; end
            acpu_pkg::OP_ANA: begin val = acc & src; upd_zs = 1'b1; pc_q[m] = n1; end
            acpu_pkg::OP_ANI: begin val = acc & imm; upd_zs = 1'b1; pc_q[m] = n2; end
            acpu_pkg::OP_ORA: begin val = acc | src; upd_zs = 1'b1; pc_q[m] = n1; end
            acpu_pkg::OP_ORI: begin val = acc | imm; upd_zs = 1'b1; pc_q[m] = n2; end
            acpu_pkg::OP_XRA: begin val = acc ^ src; upd_zs = 1'b1; pc_q[m] = n1; end
            acpu_pkg::OP_XRI: begin val = acc ^ imm; upd_zs = 1'b1; pc_q[m] = n2; end
            acpu_pkg::OP_RAL: begin
                regs[m][0] = {acc[6:0], acc[7]};
                pc_q[m] = n1;
            end
            acpu_pkg::OP_RAR: begin
                regs[m][0] = {acc[0], acc[7:1]};
                pc_q[m] = n1;
            end
            acpu_pkg::OP_HWR: begin
                mem_byte[m][it.haddr] = it.hdata;
                mem_set[m][it.haddr] = 1'b1;
            end
            default: ;
        endcase
        // Accumulator arithmetic and logic results land in the accumulator with zero and sign.
        if (upd_zs) begin
            regs[m][0] = val;
            zf_q[m] = (val == 8'd0);
            sf_q[m] = val[7];
        end
        res.pc    = pc_q[m];
        res.acc   = regs[m][0];
        res.zero  = zf_q[m];
        res.sign  = sf_q[m];
        res.carry = cf_q[m];
        return res;
    endfunction

    function automatic bit takes_word(input logic [4:0] op);
        case (acpu_pkg::t_op'(op))
            acpu_pkg::OP_STA, acpu_pkg::OP_LDA, acpu_pkg::OP_JMP, acpu_pkg::OP_JZ,
            acpu_pkg::OP_JNZ, acpu_pkg::OP_JM, acpu_pkg::OP_CALL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit takes_byte(input logic [4:0] op);
        case (acpu_pkg::t_op'(op))
            acpu_pkg::OP_MVI, acpu_pkg::OP_ANI, acpu_pkg::OP_ORI,
            acpu_pkg::OP_XRI: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic queue_instr(input t_instr it);
        instr_queue.push_back(it);
        void'(run_instr(PlanCpu, it));
    endtask

    task automatic load_byte(input logic [15:0] addr, input logic [7:0] data);
        t_instr it;
        it = '{op: acpu_pkg::OP_HWR, dsel: 3'($urandom_range(7)),
               ssel: 3'($urandom_range(7)), haddr: addr, hdata: data};
        queue_instr(it);
    endtask

    // Queue one instruction, loading its operand bytes first so that no read
    // ever touches memory that was never written.
    task automatic issue(input logic [4:0] op, input logic [2:0] dsel,
                         input logic [2:0] ssel, input logic [7:0] lo,
                         input logic [7:0] hi);
        t_instr      it;
        logic [15:0] pc;
        logic [15:0] target;
        pc = pc_q[PlanCpu];
        if (takes_byte(op) || takes_word(op)) begin
            load_byte(pc + 16'd1, lo);
            load_byte(pc + 16'd2, hi);
        end
        target = {hi, lo};
        if (acpu_pkg::t_op'(op) == acpu_pkg::OP_LDA && !mem_set[PlanCpu][target])
            load_byte(target, 8'($urandom));
        if (acpu_pkg::t_op'(op) == acpu_pkg::OP_RET) begin
            if (!mem_set[PlanCpu][acpu_pkg::RetLowSlot])
                load_byte(acpu_pkg::RetLowSlot, 8'($urandom));
            if (!mem_set[PlanCpu][acpu_pkg::RetHighSlot])
                load_byte(acpu_pkg::RetHighSlot, 8'($urandom));
        end
        it = '{op: op, dsel: dsel, ssel: ssel, haddr: 16'($urandom), hdata: 8'($urandom)};
        queue_instr(it);
        instr_count++;
    endtask

    task automatic random_program(input int n_items);
        int          stop_at;
        logic [4:0]  op;
        logic [15:0] tgt;
        stop_at = instr_queue.size() + n_items;
        while (instr_queue.size() < stop_at) begin
            if ($urandom_range(9) == 0) begin
                // Stray program-load write anywhere in memory.
                load_byte(16'($urandom), 8'($urandom));
            end else begin
                op = 5'($urandom_range(31));
                case ($urandom_range(3))
                    0: tgt = 16'($urandom);
                    1: tgt = 16'($urandom_range(255));
                    2: tgt = 16'hFFF0 | 16'($urandom_range(15));
                    default: tgt = pc_q[PlanCpu] + 16'($urandom_range(8));
                endcase
                issue(op, 3'($urandom_range(7)), 3'($urandom_range(7)),
                      tgt[7:0], tgt[15:8]);
            end
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (instr_queue.size() != 0 || i_valid || status_queue.size() != 0);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 result_count, field, got, want);
        error_count++;
    endtask

    // Clock and cycle limit.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Driver: offers queued instructions and predicts each accepted transfer.
    always @(posedge i_clk) begin
        t_instr it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid)
                status_queue.push_back(run_instr(CheckCpu, '{op: i_op, dsel: i_dest_select,
                    ssel: i_source_select, haddr: i_host_address, hdata: i_host_data}));
            if (instr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = instr_queue.pop_front();
                i_op            <= it.op;
                i_dest_select   <= it.dsel;
                i_source_select <= it.ssel;
                i_host_address  <= it.haddr;
                i_host_data     <= it.hdata;
                i_valid         <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random idling, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen_id != hold_req_id) begin
            hold_seen_id <= hold_req_id;
            hold_left    <= HoldCycles;
            i_stall      <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: compares each result transfer with the oldest expected status.
    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (status_queue.size() == 0) begin
                $display("result transfer with nothing expected, pc 0x%0h",
                         o_program_counter);
                error_count++;
            end else begin
                want = status_queue.pop_front();
                if (o_program_counter !== want.pc)
                    report_mismatch("pc", o_program_counter, want.pc);
                if (o_accumulator !== want.acc)
                    report_mismatch("accumulator", o_accumulator, want.acc);
                if (o_zero_flag !== want.zero)
                    report_mismatch("zero flag", o_zero_flag, want.zero);
                if (o_sign_flag !== want.sign)
                    report_mismatch("sign flag", o_sign_flag, want.sign);
                if (o_carry_flag !== want.carry)
                    report_mismatch("carry flag", o_carry_flag, want.carry);
                if (o_halted !== want.halted)
                    report_mismatch("halted", o_halted, want.halted);
                if (o_output_strobe !== want.strobe)
                    report_mismatch("output strobe", o_output_strobe, want.strobe);
            end
            result_count++;
        end
    end

    // Stimulus sequence.
    initial begin
        error_count     = 0;
        result_count    = 0;
        instr_count     = 0;
        cycle_count     = 0;
        hold_req_id     = 0;
        hold_seen_id    = 0;
        hold_left       = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_op            = '0;
        i_dest_select   = '0;
        i_source_select = '0;
        i_host_address  = '0;
        i_host_data     = '0;
        for (int m = 0; m < 2; m++) begin
            for (int r = 0; r < 8; r++)
                regs[m][r] = 8'd0;
            pc_q[m] = 16'd0;
            zf_q[m] = 1'b0;
            sf_q[m] = 1'b0;
            cf_q[m] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, carry and borrow, then every op code once.
        load_byte(16'hFFFF, 8'hFF);
        load_byte(16'h0000, 8'h00);
        issue(acpu_pkg::OP_MVI, 3'd7, 3'd0, 8'hFF, 8'h00);
        issue(acpu_pkg::OP_MVI, 3'd0, 3'd0, 8'hFF, 8'h00);
        issue(acpu_pkg::OP_ADD, 3'd0, 3'd7, 8'h00, 8'h00);
        issue(acpu_pkg::OP_SUB, 3'd0, 3'd7, 8'h00, 8'h00);
        for (int op = 0; op < 32; op++)
            issue(5'(op), 3'(op), 3'(7 - op % 8), 8'(op * 37), 8'(op * 91));
        drain();

        // Random programs under the three idling schemes.
        send_idle_pct = 34;
        recv_idle_pct = 48;
        random_program(430);
        drain();
        send_idle_pct = 48;
        recv_idle_pct = 34;
        random_program(430);
        drain();
        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_id   = hold_req_id + 1;
        random_program(430);
        drain();
        repeat (20) @(posedge i_clk);

        $display("ran %0d instructions (%0d transfers incl. program loads), %0d results",
                 instr_count, result_count, result_count);
        $display("idling schemes: sender/receiver 34/48, 48/34, none with a long hold-off");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/acpu_pkg.sv
rtl/accumulator_cpu_instruction_execute.sv
verif/tb_accumulator_cpu_instruction_execute.sv
